### hw/rtl/plru_pkg.sv
// Package for the priority-aware LRU block cache policy.
// Types, constants and the class-priority function; no dependencies.
package plru_pkg;
   localparam int KeyWidth      = 48;
   localparam int StampWidth    = 64;
   localparam int PrioWidth     = 2;
   localparam int PatWidth      = 3;
   localparam int CountOutWidth = 7;
   localparam int DefCapacity   = 64;
   localparam int MaxCapacity   = 16384;

   localparam logic [PatWidth-1:0] PatSequential = 3'd1;
   localparam logic [PatWidth-1:0] PatRandom     = 3'd2;
   localparam logic [PatWidth-1:0] PatDatabase   = 3'd6;
   localparam logic [PatWidth-1:0] PatStreaming  = 3'd7;

   // Contents of one cell, as it moves along the chain.
   typedef struct packed {
      logic                  valid;
      logic [KeyWidth-1:0]   key;
      logic [PrioWidth-1:0]  prio;
      logic [StampWidth-1:0] stamp;
   } entry_type;

   // Command to every cell during one pass.
   typedef struct packed {
      logic shift;     // rotate contents one cell toward the head
      logic write;     // tail cell takes wr_entry instead of the head's entry
   } cell_ctl_type;

   function automatic logic [PrioWidth-1:0] class_priority(
      input logic edu, input logic sec, input logic [PatWidth-1:0] pat);
      logic [PrioWidth-1:0] p;
      begin
         if (edu) p = 2'd3;
         else if (sec) p = 2'd2;
         else begin
            case (pat)
               PatSequential, PatStreaming: p = 2'd2;
               PatDatabase:                 p = 2'd1;
               PatRandom:                   p = 2'd0;
               default:                     p = 2'd1;
            endcase
         end
         return p;
      end
   endfunction
endpackage

### hw/rtl/plru_cell.sv
// One storage cell of the rotating entry chain.
// Depends on plru_pkg.
module plru_cell (
   input  logic                clock,
   input  logic                reset,
   input  plru_pkg::cell_ctl_type ctl,
   input  plru_pkg::entry_type prev_entry,
   input  plru_pkg::entry_type wr_entry,
   input  logic                head,
   output plru_pkg::entry_type entry
);
   import plru_pkg::*;

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = (head && ctl.write) ? wr_entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.key   <= entry_in.key;
      entry_ff.prio  <= entry_in.prio;
      entry_ff.stamp <= entry_in.stamp;
   end

   assign entry = entry_ff;
endmodule

### hw/rtl/priority_lru_block_cache_policy.sv
// Top level of the priority-aware LRU block cache policy.
// Depends on plru_pkg and plru_cell.
//
// A request (start high while busy low) is one beat. The entries sit in a ring
// of CAPACITY cells that rotates one place per cycle while busy; entries are
// examined at the head cell (index 0), and the entry leaving the head wraps into
// the tail cell, the only place a changed or new entry is written. Each request
// takes two full rotations: the first looks the key up (and refreshes its stamp)
// while tracking the first free position and the lowest (priority, stamp) victim;
// the second brings the ring back to its original order while writing the new
// entry at the free position, or over the victim when the store is full. The
// result beat shows on rsp_*, marked by done, which is high for a single cycle;
// the receiver cannot stall it and busy drops in the same cycle. Reset clears
// all valid bits.
module priority_lru_block_cache_policy #(
   parameter int CAPACITY = plru_pkg::DefCapacity
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [plru_pkg::KeyWidth-1:0]        req_block_sector,
   input  logic                                 req_educational_flag,
   input  logic                                 req_security_flag,
   input  logic [plru_pkg::PatWidth-1:0]        req_access_pattern,
   input  logic                                 req_admit,
   output logic                                 done,
   output logic                                 rsp_hit,
   output logic                                 rsp_inserted,
   output logic                                 rsp_evicted,
   output logic [plru_pkg::KeyWidth-1:0]        rsp_evicted_sector,
   output logic [plru_pkg::CountOutWidth-1:0]   rsp_entry_count
);
   import plru_pkg::*;

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIX  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IdxW-1:0]       pos_ff, pos_in;
   logic [StampWidth-1:0] stamp_ff, stamp_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic [KeyWidth-1:0]   key_ff;
   logic [PrioWidth-1:0]  prio_ff;
   logic                  admit_ff;
   logic [StampWidth-1:0] now_ff;
   logic                  hit_ff, hit_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IdxW-1:0]       free_pos_ff, free_pos_in;
   logic                  vic_ok_ff, vic_ok_in;
   logic [IdxW-1:0]       vic_pos_ff, vic_pos_in;
   logic [PrioWidth-1:0]  vic_prio_ff, vic_prio_in;
   logic [StampWidth-1:0] vic_stamp_ff, vic_stamp_in;
   logic [KeyWidth-1:0]   vic_key_ff, vic_key_in;
   logic                  done_ff, done_in;
   logic                  ins_ff, ins_in, ev_ff, ev_in;
   logic [KeyWidth-1:0]   ev_key_ff, ev_key_in;

   entry_type    cell_q [CAPACITY];
   entry_type    wr_entry;
   cell_ctl_type ctl;
   entry_type    head;
   logic         last;
   logic         full;

   assign head = cell_q[0];
   assign last = (pos_ff == IdxW'(CAPACITY - 1));
   assign full = (count_ff == CntW'(CAPACITY));

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         // the tail cell receives the head's entry and is the write point
         plru_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .prev_entry(cell_q[(g + 1) % CAPACITY]),
            .wr_entry  (wr_entry),
            .head      (g == CAPACITY - 1),
            .entry     (cell_q[g])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      stamp_in     = stamp_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      free_ok_in   = free_ok_ff;
      free_pos_in  = free_pos_ff;
      vic_ok_in    = vic_ok_ff;
      vic_pos_in   = vic_pos_ff;
      vic_prio_in  = vic_prio_ff;
      vic_stamp_in = vic_stamp_ff;
      vic_key_in   = vic_key_ff;
      ins_in       = ins_ff;
      ev_in        = ev_ff;
      ev_key_in    = ev_key_ff;
      done_in      = 1'b0;
      ctl.shift    = 1'b0;
      ctl.write    = 1'b0;
      wr_entry     = head;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_SCAN;
               pos_in     = '0;
               stamp_in   = stamp_ff + 1'b1;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               vic_ok_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            // head holds the entry of slot pos_ff
            ctl.shift = 1'b1;
            if (head.valid && head.key == key_ff && !hit_ff) begin
               hit_in         = 1'b1;
               ctl.write      = 1'b1;
               wr_entry.stamp = now_ff;
            end
            if (!head.valid && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_pos_in = pos_ff;
            end
            if (head.valid && (!vic_ok_ff || head.prio < vic_prio_ff ||
                (head.prio == vic_prio_ff && head.stamp < vic_stamp_ff))) begin
               vic_ok_in    = 1'b1;
               vic_pos_in   = pos_ff;
               vic_prio_in  = head.prio;
               vic_stamp_in = head.stamp;
               vic_key_in   = head.key;
            end
            pos_in = pos_ff + 1'b1;
            if (last) begin
               pos_in   = '0;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            ctl.shift = 1'b1;
            // hit: keys unique, fix pass is a plain rotation
            if (!hit_ff && admit_ff) begin
               if (full) begin
                  if (vic_ok_ff && pos_ff == vic_pos_ff) begin
                     ctl.write      = 1'b1;
                     wr_entry.valid = 1'b1;
                     wr_entry.key   = key_ff;
                     wr_entry.prio  = prio_ff;
                     wr_entry.stamp = now_ff;
                  end
               end else if (free_ok_ff && pos_ff == free_pos_ff) begin
                  ctl.write      = 1'b1;
                  wr_entry.valid = 1'b1;
                  wr_entry.key   = key_ff;
                  wr_entry.prio  = prio_ff;
                  wr_entry.stamp = now_ff;
               end
            end
            pos_in = pos_ff + 1'b1;
            if (last) begin
               pos_in   = '0;
               state_in = ST_IDLE;
               done_in  = 1'b1;
               ins_in   = 1'b0;
               ev_in    = 1'b0;
               ev_key_in = '0;
               if (!hit_ff && admit_ff) begin
                  if (full) begin
                     ins_in    = vic_ok_ff;
                     ev_in     = vic_ok_ff;
                     ev_key_in = vic_key_ff;
                  end else if (free_ok_ff) begin
                     ins_in   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         stamp_ff <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         stamp_ff <= stamp_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      if (state_ff == ST_IDLE && start) begin
         key_ff   <= req_block_sector;
         prio_ff  <= class_priority(req_educational_flag, req_security_flag,
                                    req_access_pattern);
         admit_ff <= req_admit;
         now_ff   <= stamp_ff;
      end
      hit_ff       <= hit_in;
      free_ok_ff   <= free_ok_in;
      free_pos_ff  <= free_pos_in;
      vic_ok_ff    <= vic_ok_in;
      vic_pos_ff   <= vic_pos_in;
      vic_prio_ff  <= vic_prio_in;
      vic_stamp_ff <= vic_stamp_in;
      vic_key_ff   <= vic_key_in;
      ins_ff       <= ins_in;
      ev_ff        <= ev_in;
      ev_key_ff    <= ev_key_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign done               = done_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_inserted       = ins_ff;
   assign rsp_evicted        = ev_ff;
   assign rsp_evicted_sector = ev_key_ff;
   assign rsp_entry_count    = CountOutWidth'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY)) else $error("entry count over capacity");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == ST_IDLE) else $error("result while busy");
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (done_ff && rsp_evicted) |-> rsp_inserted && full)
      else $error("eviction without insert on full store");
   a_hit_exclusive: assert property (@(posedge clock) disable iff (reset)
      (done_ff && rsp_hit) |-> !rsp_inserted && !rsp_evicted)
      else $error("hit with insert or eviction");
endmodule

### tb/plru_checker.sv
// Checker for the priority-aware LRU block cache policy.
// Watches request and result beats, predicts each result, compares it.
// Depends on plru_pkg.
`timescale 1ns / 100ps
module plru_checker #(
   parameter int CAPACITY = plru_pkg::DefCapacity
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [plru_pkg::KeyWidth-1:0]        req_block_sector,
   input  logic                                 req_educational_flag,
   input  logic                                 req_security_flag,
   input  logic [plru_pkg::PatWidth-1:0]        req_access_pattern,
   input  logic                                 req_admit,
   input  logic                                 done,
   input  logic                                 rsp_hit,
   input  logic                                 rsp_inserted,
   input  logic                                 rsp_evicted,
   input  logic [plru_pkg::KeyWidth-1:0]        rsp_evicted_sector,
   input  logic [plru_pkg::CountOutWidth-1:0]   rsp_entry_count,
   output int                                   fail_count,
   output int                                   pending
);
   import plru_pkg::*;

   typedef struct packed {
      logic                     hit;
      logic                     inserted;
      logic                     evicted;
      logic [KeyWidth-1:0]      evicted_sector;
      logic [CountOutWidth-1:0] entry_count;
   } outcome_t;

   logic [KeyWidth-1:0]   line_key   [CAPACITY];
   logic                  line_valid [CAPACITY];
   logic [PrioWidth-1:0]  line_prio  [CAPACITY];
   logic [StampWidth-1:0] line_stamp [CAPACITY];
   logic [StampWidth-1:0] age_now;
   int                    lines_used;
   outcome_t              outcome_q[$];

   function automatic logic [PrioWidth-1:0] rank_of(
      logic edu, logic sec, logic [PatWidth-1:0] pat);
      if (edu) return 2'd3;
      if (sec) return 2'd2;
      case (pat)
         PatSequential, PatStreaming: return 2'd2;
         PatDatabase:                 return 2'd1;
         PatRandom:                   return 2'd0;
         default:                     return 2'd1;
      endcase
   endfunction

   // Applies one request to the shadow store and returns its outcome.
   function automatic outcome_t access_line(logic [KeyWidth-1:0] key, logic edu,
         logic sec, logic [PatWidth-1:0] pat, logic adm);
      outcome_t o;
      int slot, victim;
      logic [StampWidth-1:0] stamp;
      o = '0;
      slot = -1;
      victim = -1;
      stamp = age_now;
      age_now = age_now + 1;
      for (int i = 0; i < CAPACITY; i++)
         if (slot < 0 && line_valid[i] && line_key[i] == key) slot = i;
      if (slot >= 0) begin
         o.hit = 1'b1;
         line_stamp[slot] = stamp;
      end else if (adm) begin
         if (lines_used >= CAPACITY) begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (!line_valid[i]) continue;
               if (victim < 0 || line_prio[i] < line_prio[victim] ||
                   (line_prio[i] == line_prio[victim] &&
                    line_stamp[i] < line_stamp[victim]))
                  victim = i;
            end
            if (victim >= 0) begin
               o.evicted = 1'b1;
               o.evicted_sector = line_key[victim];
               line_valid[victim] = 1'b0;
               lines_used--;
            end
         end
         for (int i = 0; i < CAPACITY; i++)
            if (slot < 0 && !line_valid[i]) slot = i;
         if (slot >= 0) begin
            line_key[slot] = key;
            line_valid[slot] = 1'b1;
            line_prio[slot] = rank_of(edu, sec, pat);
            line_stamp[slot] = stamp;
            lines_used++;
            o.inserted = 1'b1;
         end
      end
      o.entry_count = lines_used[CountOutWidth-1:0];
      return o;
   endfunction

   assign pending = outcome_q.size();

   always @(posedge clock) begin
      outcome_t exp_o;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) line_valid[i] = 1'b0;
         age_now = '0;
         lines_used = 0;
         fail_count = 0;
         outcome_q.delete();
      end else begin
         // result first: a new beat is accepted in the cycle done drops busy
         if (done) begin
            if (outcome_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               exp_o = outcome_q.pop_front();
               if (rsp_hit !== exp_o.hit) begin
                  $error("hit exp %0d got %0d", exp_o.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_inserted !== exp_o.inserted) begin
                  $error("inserted exp %0d got %0d", exp_o.inserted, rsp_inserted);
                  fail_count++;
               end
               if (rsp_evicted !== exp_o.evicted) begin
                  $error("evicted exp %0d got %0d", exp_o.evicted, rsp_evicted);
                  fail_count++;
               end
               if (rsp_evicted_sector !== exp_o.evicted_sector) begin
                  $error("evicted_sector exp %h got %h",
                         exp_o.evicted_sector, rsp_evicted_sector);
                  fail_count++;
               end
               if (rsp_entry_count !== exp_o.entry_count) begin
                  $error("entry_count exp %0d got %0d",
                         exp_o.entry_count, rsp_entry_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            outcome_q.push_back(access_line(req_block_sector, req_educational_flag,
               req_security_flag, req_access_pattern, req_admit));
      end
   end
endmodule

### tb/tb_top.sv
// Top of the cache-policy testbench: clock, reset, request stimulus, verdict.
// Depends on plru_pkg, plru_checker and the block under test.
`timescale 1ns / 100ps
module tb_top;
   import plru_pkg::*;

   localparam int NumRandom  = 1030;
   localparam int StallLimit = 4000;   // cycles with no beat accepted or completed

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [KeyWidth-1:0]      req_block_sector = '0;
   logic                     req_educational_flag = 1'b0;
   logic                     req_security_flag = 1'b0;
   logic [PatWidth-1:0]      req_access_pattern = '0;
   logic                     req_admit = 1'b0;
   logic                     done;
   logic                     rsp_hit, rsp_inserted, rsp_evicted;
   logic [KeyWidth-1:0]      rsp_evicted_sector;
   logic [CountOutWidth-1:0] rsp_entry_count;
   int                       fail_count, pending;
   int                       idle_cycles = 0;
   bit                       calm = 1'b0;   // stretch with no gaps between beats
   logic [KeyWidth-1:0]      hot_keys[16];  // small key pool so hits and evictions occur

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   priority_lru_block_cache_policy u_top (.*);

   plru_checker u_check (.*);

   // Watchdog: ends the run as a mismatch if the block stalls past StallLimit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("priority_lru_block_cache_policy: mismatch");
         $finish;
      end
   end

   // Drive one request beat and hold it until it is taken; start stays high
   // into the next request unless that one opens with an idle gap.
   task automatic send_request(logic [KeyWidth-1:0] key, logic edu, logic sec,
         logic [PatWidth-1:0] pat, logic adm);
      if (!calm)
         while ($urandom_range(99) < 18) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start                <= 1'b1;
      req_block_sector     <= key;
      req_educational_flag <= edu;
      req_security_flag    <= sec;
      req_access_pattern   <= pat;
      req_admit            <= adm;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [KeyWidth-1:0] key;
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 16; i++) hot_keys[i] = KeyWidth'({$urandom, $urandom});

      // Directed: key extremes, every pattern and class, hit, miss without admit.
      send_request('0, 1'b0, 1'b0, 3'd0, 1'b1);
      send_request('1, 1'b1, 1'b1, 3'd7, 1'b1);
      send_request('0, 1'b0, 1'b0, 3'd0, 1'b1);            // hit
      send_request(48'h5555_5555_5555, 1'b0, 1'b0, 3'd2, 1'b0); // miss, no admit
      for (int p = 0; p < 8; p++)
         send_request(48'h100 + p, 1'b0, 1'b0, p[2:0], 1'b1);
      send_request(48'hAAAA_AAAA_AAAA, 1'b0, 1'b1, 3'd2, 1'b1);
      send_request(48'h1, 1'b1, 1'b0, 3'd2, 1'b1);

      // Random: mostly admitted keys drawn from a pool wider than the store,
      // so the store fills, evicts by priority and age, and sees hits.
      for (int n = 0; n < NumRandom; n++) begin
         calm = (n >= 400 && n < 550);
         pick = $urandom_range(99);
         if (pick < 70) key = 48'h2000 + $urandom_range(95);
         else if (pick < 85) key = hot_keys[$urandom_range(15)];
         else key = KeyWidth'({$urandom, $urandom});
         send_request(key, ($urandom_range(9) == 0), ($urandom_range(7) == 0),
                      PatWidth'($urandom_range(7)), ($urandom_range(99) < 88));
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (140) @(posedge clock);
      if (fail_count == 0) $display("priority_lru_block_cache_policy: match");
      else $display("priority_lru_block_cache_policy: mismatch");
      $finish;
   end
endmodule

### files.f
hw/rtl/plru_pkg.sv
hw/rtl/plru_cell.sv
hw/rtl/priority_lru_block_cache_policy.sv
tb/plru_checker.sv
tb/tb_top.sv
